### src/eased_spline_path_generator_assert.svh
// Assertion macros for the eased spline path generator.
// Expects clk and rst in the scope of the including module.
`ifndef EASED_SPLINE_PATH_GENERATOR_ASSERT_SVH
`define EASED_SPLINE_PATH_GENERATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ESP_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// antecedent implies consequent in the next cycle
`define ESP_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

### src/esp_pkg.sv
// Shared types and constants for the eased spline path generator.
// No dependencies.
package esp_pkg;

  localparam int DUR_W   = 25;
  localparam int CNT_W   = 4;
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 3;
  localparam int DT_W    = 20;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_POINTS_DEF = 8;
  localparam int COORD_BITS_DEF = 16;
  localparam int PHASE_BITS_DEF = 16;

  localparam logic [DUR_W-1:0] DUR_RESET = 25'd10000000;

  localparam logic [CFG_IDX_W-1:0] REG_LOOP_DURATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT   = 1'd1;

  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_PHASE, S_EASE, S_MAP, S_READ, S_HORN, S_DONE
  } state_t;

endpackage

### src/esp_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module esp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/eased_spline_path_generator.sv
// Eased closed-loop Catmull-Rom path generator. Once a tick word is taken the
// input stays stalled through a bit-serial divider for the time modulo (26 steps)
// and the phase (PHASE_BITS steps), then one shared shift-add multiplier, one bit
// per cycle, for two ease products and nine Horner products. With one to three
// points a tick skips the phase divide and the ease and Horner products, and with
// none also the point reads; any tick stalls longer while an earlier result
// still waits. Load, restart and held words, and ticks while the loop duration
// is zero, do not stall the input. A finished result waits in the output
// register while the next word is taken.
// Depends on esp_pkg, esp_ram and eased_spline_path_generator_assert.svh.
module eased_spline_path_generator #(
  parameter int MAX_POINTS = esp_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = esp_pkg::COORD_BITS_DEF,
  parameter int PHASE_BITS = esp_pkg::PHASE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [esp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esp_pkg::DUR_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [esp_pkg::MODE_W-1:0]     mode,
  input  logic [esp_pkg::IDX_W-1:0]      point_index,
  input  logic signed [COORD_BITS-1:0]   point_x,
  input  logic signed [COORD_BITS-1:0]   point_y,
  input  logic signed [COORD_BITS-1:0]   point_z,
  input  logic [esp_pkg::DT_W-1:0]       delta_time,
  input  logic                           hold,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [COORD_BITS-1:0]   target_x,
  output logic signed [COORD_BITS-1:0]   target_y,
  output logic signed [COORD_BITS-1:0]   target_z
);

  import esp_pkg::*;

  localparam int PB    = PHASE_BITS + 1;
  localparam int ACC_W = COORD_BITS + 6;
  localparam int MW    = (ACC_W > PHASE_BITS + 3) ? ACC_W : PHASE_BITS + 3;
  localparam int PW    = MW + PB;
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int NW    = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = DUR_W + 1;
  localparam int DCW   = $clog2(SUM_W + 1);
  localparam int MCW   = $clog2(PB + 1);
  localparam int RW    = 3 * COORD_BITS;
  localparam logic [PB:0] ONE_X = (PB + 1)'(1) << PHASE_BITS;
  localparam logic signed [PW-1:0] HALF_LSB = PW'(1) <<< (PHASE_BITS - 1);
  localparam logic signed [MW-1:0] CMAX = MW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [MW-1:0] CMIN = -CMAX - MW'(1);

  state_t state, state_next;

  logic [DUR_W-1:0] loop_duration;
  logic [CNT_W-1:0] point_count;
  logic [DUR_W-1:0] elapsed;

  // divider
  logic [DUR_W-1:0]      div_rem;
  logic [SUM_W-1:0]      div_dvd;
  logic [PHASE_BITS-1:0] div_q;
  logic [DCW-1:0]        dcnt;
  logic [SUM_W-1:0]      div_t;
  logic                  div_geq;
  logic [SUM_W-1:0]      div_sub;

  // multiplier
  logic signed [PW-1:0] mcand, prod, rsum, rfull;
  logic [PB-1:0]        mplier;
  logic [MCW-1:0]       mcnt;
  logic signed [MW-1:0] r;

  // ease and mapping
  logic                  lo;
  logic [PHASE_BITS-1:0] tph;
  logic [PB-1:0]         fval;
  logic [PB:0]           omq;
  logic                  eop;
  logic [PHASE_BITS-1:0] ease_e, e_new;
  logic [PHASE_BITS-1:0] s;
  logic [NW-1:0]         n;
  logic [PHASE_BITS+NW-1:0] u;
  logic [NW-1:0]         seg;
  logic [NW:0]           i0, i1, i2, i3;
  logic                  direct;

  // point fetch and Horner
  logic [AW-1:0]  idx [4];
  logic [RW-1:0]  pts [4];
  logic [2:0]     rcnt;
  logic [AW-1:0]  raddr;
  logic [RW-1:0]  rdata;
  logic [1:0]     k, hop, ksel;
  logic signed [COORD_BITS-1:0] q0, q1, q2, q3;
  logic signed [MW-1:0] c0, c1, c2, c3, ca, cb, cc, cd, coef, acc_new, half;
  logic signed [COORD_BITS-1:0] sat, res [3];

  // load port
  logic          ram_we;
  logic [AW-1:0] waddr;
  logic [31:0]   idx_ext;

  logic accept, tick_go;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign tick_go  = (mode == MODE_TICK) && !hold && (loop_duration != '0);
  assign idx_ext  = 32'(point_index);
  assign waddr    = idx_ext[AW-1:0];
  assign ram_we   = accept && (mode == MODE_LOAD) && (idx_ext < MAX_POINTS);
  assign raddr    = idx[rcnt[1:0]];

  esp_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_points (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({point_z, point_y, point_x}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    n = (int'(point_count) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(point_count);
    // restoring divide step
    div_t   = {div_rem, div_dvd[SUM_W-1]};
    div_geq = div_t >= {1'b0, loop_duration};
    div_sub = div_t - {1'b0, loop_duration};
    // rounding shift of the product
    rsum  = prod + HALF_LSB;
    rfull = rsum >>> PHASE_BITS;
    r     = rfull[MW-1:0];
    omq   = ONE_X - {2'b00, div_q};
    e_new = lo ? r[PHASE_BITS-1:0] : PHASE_BITS'(-(r >>> 1));
    // segment mapping
    u   = (PHASE_BITS + NW)'(ease_e) * (PHASE_BITS + NW)'(n);
    seg = u[PHASE_BITS+NW-1:PHASE_BITS];
    i1  = {1'b0, seg};
    i0  = (seg == '0) ? {1'b0, n} - (NW + 1)'(1) : i1 - (NW + 1)'(1);
    i2  = i1 + (NW + 1)'(1);
    if (i2 >= {1'b0, n}) begin
      i2 = i2 - {1'b0, n};
    end
    i3  = i1 + (NW + 1)'(2);
    if (i3 >= {1'b0, n}) begin
      i3 = i3 - {1'b0, n};
    end
    // coefficients of the selected coordinate
    ksel = k;
    q0 = pts[0][ksel*COORD_BITS +: COORD_BITS];
    q1 = pts[1][ksel*COORD_BITS +: COORD_BITS];
    q2 = pts[2][ksel*COORD_BITS +: COORD_BITS];
    q3 = pts[3][ksel*COORD_BITS +: COORD_BITS];
    c0 = MW'(q0);
    c1 = MW'(q1);
    c2 = MW'(q2);
    c3 = MW'(q3);
    ca = c1 <<< 1;
    cb = c2 - c0;
    cc = (c0 <<< 1) - ((c1 <<< 2) + c1) + (c2 <<< 2) - c3;
    cd = c3 - c0 + ((c1 <<< 1) + c1) - ((c2 <<< 1) + c2);
    case (hop)
      2'd0:    coef = cc;
      2'd1:    coef = cb;
      default: coef = ca;
    endcase
    acc_new = r + coef;
    half    = (acc_new + MW'(1)) >>> 1;
    if (half > CMAX) begin
      sat = CMAX[COORD_BITS-1:0];
    end else if (half < CMIN) begin
      sat = CMIN[COORD_BITS-1:0];
    end else begin
      sat = half[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && tick_go) begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (dcnt == '0) begin
          if (n == '0) begin
            state_next = S_DONE;
          end else if (n < NW'(4)) begin
            state_next = S_READ;
          end else begin
            state_next = S_PHASE;
          end
        end
      end
      S_PHASE: begin
        if (dcnt == '0) begin
          state_next = S_EASE;
        end
      end
      S_EASE: begin
        if (mcnt == '0 && eop) begin
          state_next = S_MAP;
        end
      end
      S_MAP:  state_next = S_READ;
      S_READ: begin
        if (rcnt == 3'd4) begin
          state_next = direct ? S_DONE : S_HORN;
        end
      end
      S_HORN: begin
        if (mcnt == '0 && hop == 2'd2 && k == 2'd2) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_duration <= DUR_RESET;
      point_count   <= '0;
      elapsed       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LOOP_DURATION: loop_duration <= cfg_data;
          REG_POINT_COUNT:   point_count   <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (accept && mode == MODE_RESTART) begin
        elapsed <= '0;
      end
      if (state == S_MOD && dcnt == '0) begin
        elapsed <= div_rem;
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      target_x <= res[0];
      target_y <= res[1];
      target_z <= res[2];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (mcnt != '0) begin
      prod   <= prod + (mplier[0] ? mcand : '0);
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
      mcnt   <= mcnt - MCW'(1);
    end
    case (state)
      S_IDLE: begin
        mcnt <= '0;
        if (in_valid && tick_go) begin
          div_rem <= '0;
          div_dvd <= {1'b0, elapsed} + SUM_W'(delta_time);
          dcnt    <= DCW'(SUM_W);
        end
      end
      S_MOD, S_PHASE: begin
        if (dcnt != '0) begin
          div_rem <= div_geq ? div_sub[DUR_W-1:0] : div_t[DUR_W-1:0];
          div_dvd <= div_dvd << 1;
          div_q   <= {div_q[PHASE_BITS-2:0], div_geq};
          dcnt    <= dcnt - DCW'(1);
        end else if (state == S_MOD) begin
          // remainder is the new elapsed time and seeds the phase divide
          div_dvd <= '0;
          dcnt    <= DCW'(PHASE_BITS);
          direct  <= 1'b1;
          rcnt    <= '0;
          for (int j = 0; j < 4; j++) begin
            idx[j] <= '0;
          end
          res[0] <= '0;
          res[1] <= '0;
          res[2] <= '0;
        end else begin
          tph    <= div_q;
          lo     <= !div_q[PHASE_BITS-1];
          fval   <= {omq[PB-2:0], 1'b0};
          eop    <= 1'b0;
          prod   <= '0;
          mcnt   <= MCW'(PB);
          mcand  <= div_q[PHASE_BITS-1] ? PW'({omq[PB-2:0], 1'b0}) : PW'(div_q);
          mplier <= div_q[PHASE_BITS-1] ? {omq[PB-2:0], 1'b0} : PB'(div_q);
        end
      end
      S_EASE: begin
        if (mcnt == '0) begin
          if (!eop) begin
            eop    <= 1'b1;
            prod   <= '0;
            mcnt   <= MCW'(PB);
            mcand  <= lo ? PW'(r <<< 2) : PW'(r);
            mplier <= lo ? PB'(tph) : fval;
          end else begin
            ease_e <= e_new;
          end
        end
      end
      S_MAP: begin
        s      <= u[PHASE_BITS-1:0];
        idx[0] <= i0[AW-1:0];
        idx[1] <= i1[AW-1:0];
        idx[2] <= i2[AW-1:0];
        idx[3] <= i3[AW-1:0];
        direct <= 1'b0;
        rcnt   <= '0;
      end
      S_READ: begin
        rcnt <= rcnt + 3'd1;
        if (rcnt != '0) begin
          pts[rcnt[1:0] - 2'd1] <= rdata;
        end
        if (rcnt == 3'd4) begin
          if (direct) begin
            res[0] <= rdata[COORD_BITS-1:0];
            res[1] <= rdata[2*COORD_BITS-1:COORD_BITS];
            res[2] <= rdata[RW-1:2*COORD_BITS];
          end
          k   <= '0;
          hop <= '0;
        end
      end
      S_HORN: begin
        if (rcnt == 3'd5) begin
          // start of a coordinate: all four points are in place
          rcnt   <= '0;
          prod   <= '0;
          mplier <= {1'b0, s};
          mcand  <= PW'(cd);
          mcnt   <= MCW'(PB);
        end else if (mcnt == '0) begin
          prod   <= '0;
          mplier <= {1'b0, s};
          if (hop != 2'd2) begin
            hop   <= hop + 2'd1;
            mcand <= PW'(acc_new);
            mcnt  <= MCW'(PB);
          end else begin
            res[k] <= sat;
            hop    <= '0;
            k      <= k + 2'd1;
            rcnt   <= 3'd5;
          end
        end
      end
      default: ;
    endcase
  end

  `include "eased_spline_path_generator_assert.svh"

  `ESP_CHECK_NEXT(a_mod_reduces, state == S_MOD && dcnt == '0, elapsed < loop_duration)
  `ESP_CHECK_NEXT(a_tick_starts,
    in_valid && in_ready && tick_go, state == S_MOD)
  `ESP_CHECK(a_mult_bound, 1'b1, mcnt <= MCW'(PB))
  `ESP_CHECK(a_read_bound, state == S_READ, rcnt <= 3'd4)
  `ESP_CHECK(a_coord_bound, state == S_HORN, k != 2'd3)

endmodule
